// ===== rtl/sas_pkg.sv =====
// Shared types, constants and lookup functions of the sprite animation sequencer.
package sas_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_SLOTS   = 8;
	localparam int DEF_QUEUE_DEPTH = 8;

	// Field widths fixed by the interface
	localparam int MODE_W    = 2;
	localparam int ID_W      = 3;
	localparam int ELAPSED_W = 16;
	localparam int FRAME_W   = 8;
	localparam int LEVEL_W   = 4;
	localparam int ACC_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_PLAY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STOP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEFINED_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MASK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNTS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMES_LOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMES_HIGH   = 3'd4;

	// Configuration reset values
	localparam logic [7:0]       RST_DEFINED_MASK = 8'hFF;
	localparam logic [7:0]       RST_LOOP_MASK    = 8'h00;
	localparam logic [CFG_W-1:0] RST_FRAME_COUNTS = 64'h0101_0101_0101_0101;
	localparam logic [CFG_W-1:0] RST_FRAME_TIMES  = 64'h0001_0001_0001_0001;

	// Iterative divider: 18-bit dividend, 16-bit divisor, two bits per cycle
	localparam int DIV_W     = 18;
	localparam int DVS_W     = 16;
	localparam int DIV_STEPS = 2;
	localparam int DIV_CYC   = DIV_W / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

	typedef struct packed {
		logic [7:0]       defined_mask;
		logic [7:0]       loop_mask;
		logic [CFG_W-1:0] frame_counts;
		logic [CFG_W-1:0] frame_times_low;
		logic [CFG_W-1:0] frame_times_high;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // latch the accepted request
		logic simple;    // play, stop, no-op or idle tick
		logic prep;      // tick: saturating add, fetch count and time
		logic div_start; // launch the divider
		logic div_sel;   // 0: acc / frame time, 1: frame wrap by count
		logic save_qr;   // keep quotient and remainder of first divide
		logic mul;       // one-shot: need * frame time
		logic wb;        // write back slot state, dequeue on finish
		logic out_load;  // capture the result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic tick_go;   // tick with an animation playing
		logic slot_loop; // current slot loops
		logic q_zero;    // no whole frame elapsed
		logic div_busy;
	} status_t;

	// Frame count of a slot, zero read as one
	function automatic logic [FRAME_W-1:0] slot_count(cfg_t c, logic [ID_W-1:0] s);
		logic [FRAME_W-1:0] v;
		v = c.frame_counts[{s, 3'b000} +: FRAME_W];
		return (v == '0) ? FRAME_W'(1) : v;
	endfunction

	// Frame time of a slot, zero read as one
	function automatic logic [DVS_W-1:0] slot_time(cfg_t c, logic [ID_W-1:0] s);
		logic [CFG_W-1:0] w;
		logic [DVS_W-1:0] v;
		w = s[2] ? c.frame_times_high : c.frame_times_low;
		v = w[{s[1:0], 4'b0000} +: DVS_W];
		return (v == '0) ? DVS_W'(1) : v;
	endfunction

endpackage

// ===== rtl/sas_cfg.sv =====
// Configuration register file of the sprite animation sequencer.
module sas_cfg import sas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.defined_mask     <= RST_DEFINED_MASK;
			cfg_q.loop_mask        <= RST_LOOP_MASK;
			cfg_q.frame_counts     <= RST_FRAME_COUNTS;
			cfg_q.frame_times_low  <= RST_FRAME_TIMES;
			cfg_q.frame_times_high <= RST_FRAME_TIMES;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEFINED_MASK: cfg_q.defined_mask     <= cfg_wr_data[7:0];
				CFG_LOOP_MASK:    cfg_q.loop_mask        <= cfg_wr_data[7:0];
				CFG_FRAME_COUNTS: cfg_q.frame_counts     <= cfg_wr_data;
				CFG_TIMES_LOW:    cfg_q.frame_times_low  <= cfg_wr_data;
				CFG_TIMES_HIGH:   cfg_q.frame_times_high <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sas_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
module sas_div import sas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] left_q;
	logic                 busy_q;
	logic [DIV_W-1:0]     quo_d;
	logic [DVS_W-1:0]     rem_d;

	// Two shift-and-subtract steps
	always_comb begin
		logic [DVS_W:0] trial;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_d, quo_d[DIV_W-1]};
			quo_d = {quo_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial = trial - {1'b0, dvs_q};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[DVS_W-1:0];
		end
	end

	// Control: count down the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			left_q <= DIV_CNT_W'(DIV_CYC);
		end else if (busy_q) begin
			left_q <= left_q - DIV_CNT_W'(1);
			if (left_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/sas_datapath.sv =====
// Datapath: slot state, request queue, frame arithmetic and result register.
module sas_datapath import sas_pkg::*; #(
	parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  cfg_t                 cfg,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ID_W-1:0]      anim_id,
	input  logic                 restart,
	input  logic [ELAPSED_W-1:0] elapsed,
	output logic                 playing,
	output logic [ID_W-1:0]      anim_now,
	output logic [FRAME_W-1:0]   frame_now,
	output logic                 finished_now,
	output logic [LEVEL_W-1:0]   queue_level,
	output logic                 dropped
);

	localparam int SLOT_W  = $clog2(NUM_SLOTS);
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = COUNT_W + 1;

	// Latched request
	logic [MODE_W-1:0]    mode_q;
	logic [ID_W-1:0]      id_q;
	logic                 restart_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	// Playback state
	logic                 cur_valid_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic [FRAME_W-1:0]   frame_q [NUM_SLOTS];
	logic [ACC_W-1:0]     acc_q   [NUM_SLOTS];
	logic                 fin_q   [NUM_SLOTS];
	logic [PTR_W-1:0]     head_q;
	logic [COUNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]    queue_mem [QUEUE_DEPTH];
	logic [SLOT_W-1:0]    head_rd_q;

	// Tick working registers
	logic [ACC_W-1:0]     sum_q;
	logic [FRAME_W-1:0]   cnt_q;
	logic [DVS_W-1:0]     ft_q;
	logic [FRAME_W-1:0]   f_q;
	logic                 loop_q;
	logic [ACC_W-1:0]     q_q;
	logic [DVS_W-1:0]     r_q;
	logic [FRAME_W-1:0]   need_q;
	logic [FRAME_W+DVS_W-1:0] prod_q;
	logic                 fin_now_q;
	logic                 drop_q;

	// Result register
	logic                 playing_q;
	logic [ID_W-1:0]      anim_now_q;
	logic [FRAME_W-1:0]   frame_now_q;
	logic                 finished_now_q;
	logic [LEVEL_W-1:0]   queue_level_q;
	logic                 dropped_q;

	// Divider
	logic                 div_busy;
	logic [DIV_W-1:0]     div_quo;
	logic [DVS_W-1:0]     div_rem;
	logic [DIV_W-1:0]     div_dividend;
	logic [DVS_W-1:0]     div_divisor;
	logic [DIV_W-1:0]     wrap_dividend;

	// Request decode
	logic [SLOT_W-1:0]    id_slot;
	logic                 id_ok;
	logic                 id_loop;
	logic                 q_full;
	logic                 enq_en;
	logic [SUM_W-1:0]     tail_sum;
	logic [SUM_W-1:0]     tail_wrap;
	logic [PTR_W-1:0]     tail_idx;
	logic [PTR_W-1:0]     head_next;
	logic [ACC_W:0]       sum_raw;
	logic [FRAME_W-1:0]   need;
	logic [COUNT_W+LEVEL_W-1:0] level_ext;

	// Write-back values
	logic [FRAME_W-1:0]   new_f;
	logic [ACC_W-1:0]     new_acc;
	logic                 set_fin;
	logic                 go_next;

	assign id_slot  = id_q[SLOT_W-1:0];
	assign id_ok    = ((ID_W+1)'(id_q) < (ID_W+1)'(NUM_SLOTS)) && cfg.defined_mask[id_q];
	assign id_loop  = cfg.loop_mask[id_q];
	assign q_full   = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign enq_en   = cmd.simple && (mode_q == MODE_PLAY) && id_ok && cur_valid_q
		&& !id_loop && !q_full;

	// Queue tail and head wrap
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
		: tail_sum;
	assign tail_idx  = tail_wrap[PTR_W-1:0];
	assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// Saturating accumulate
	assign sum_raw = {1'b0, acc_q[cur_slot_q]} + (ACC_W+1)'(elapsed_q);

	// Divider operand select
	assign wrap_dividend = (f_q < cnt_q) ? DIV_W'(f_q) + DIV_W'(q_q)
		: DIV_W'(q_q) - DIV_W'(1);
	assign div_dividend  = cmd.div_sel ? wrap_dividend : DIV_W'(sum_q);
	assign div_divisor   = cmd.div_sel ? DVS_W'(cnt_q) : ft_q;

	sas_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Frames a one-shot still needs to finish
	assign need = (f_q < cnt_q) ? cnt_q - f_q : FRAME_W'(1);

	// Frame and accumulator after the tick
	always_comb begin
		new_f   = f_q;
		new_acc = ACC_W'(r_q);
		set_fin = 1'b0;
		if (loop_q) begin
			if (q_q != '0) begin
				new_f = div_rem[FRAME_W-1:0];
			end
		end else if (q_q >= ACC_W'(need_q)) begin
			new_f   = cnt_q - FRAME_W'(1);
			new_acc = sum_q - prod_q[ACC_W-1:0];
			set_fin = 1'b1;
		end else begin
			new_f = f_q + q_q[FRAME_W-1:0];
		end
	end

	assign go_next = (fin_q[cur_slot_q] || set_fin) && !loop_q;

	// Latch request and tick operands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode;
			id_q      <= anim_id;
			restart_q <= restart;
			elapsed_q <= elapsed;
		end
		if (cmd.prep) begin
			sum_q  <= sum_raw[ACC_W] ? {ACC_W{1'b1}} : sum_raw[ACC_W-1:0];
			cnt_q  <= slot_count(cfg, ID_W'(cur_slot_q));
			ft_q   <= slot_time(cfg, ID_W'(cur_slot_q));
			f_q    <= frame_q[cur_slot_q];
			loop_q <= cfg.loop_mask[ID_W'(cur_slot_q)];
		end
		if (cmd.save_qr) begin
			q_q <= div_quo[ACC_W-1:0];
			r_q <= div_rem;
		end
		if (cmd.mul) begin
			need_q <= need;
			prod_q <= need * ft_q;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (enq_en) begin
			queue_mem[tail_idx] <= id_slot;
		end
		head_rd_q <= queue_mem[head_q];
	end

	// Playback state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			head_q      <= '0;
			count_q     <= '0;
			fin_now_q   <= 1'b0;
			drop_q      <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				frame_q[i] <= '0;
				acc_q[i]   <= '0;
				fin_q[i]   <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				fin_now_q <= 1'b0;
				drop_q    <= 1'b0;
			end
			if (cmd.simple) begin
				case (mode_q)
					MODE_PLAY: begin
						if (id_ok) begin
							if (cur_valid_q && !id_loop) begin
								if (q_full) begin
									drop_q <= 1'b1;
								end else begin
									count_q <= count_q + COUNT_W'(1);
								end
							end else begin
								cur_valid_q <= 1'b1;
								cur_slot_q  <= id_slot;
								if (restart_q || fin_q[id_slot]) begin
									frame_q[id_slot] <= '0;
									acc_q[id_slot]   <= '0;
									fin_q[id_slot]   <= 1'b0;
								end
							end
						end
					end
					MODE_STOP: begin
						if (cur_valid_q && cfg.loop_mask[ID_W'(cur_slot_q)]) begin
							cur_valid_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.wb) begin
				frame_q[cur_slot_q] <= new_f;
				acc_q[cur_slot_q]   <= new_acc;
				fin_now_q           <= set_fin;
				if (set_fin) begin
					fin_q[cur_slot_q] <= 1'b1;
				end
				// Finished one-shot: start the next queued slot or go idle
				if (go_next) begin
					if (count_q != '0) begin
						head_q              <= head_next;
						count_q             <= count_q - COUNT_W'(1);
						cur_slot_q          <= head_rd_q;
						frame_q[head_rd_q]  <= '0;
						acc_q[head_rd_q]    <= '0;
						fin_q[head_rd_q]    <= 1'b0;
					end else begin
						cur_valid_q <= 1'b0;
					end
				end
			end
		end
	end

	assign level_ext = (COUNT_W+LEVEL_W)'(count_q);

	// Result capture
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			playing_q      <= cur_valid_q;
			anim_now_q     <= cur_valid_q ? ID_W'(cur_slot_q) : '0;
			frame_now_q    <= cur_valid_q ? frame_q[cur_slot_q] : '0;
			finished_now_q <= fin_now_q;
			queue_level_q  <= level_ext[LEVEL_W-1:0];
			dropped_q      <= drop_q;
		end
	end

	assign status.tick_go   = (mode_q == MODE_TICK) && cur_valid_q;
	assign status.slot_loop = loop_q;
	assign status.q_zero    = (q_q == '0);
	assign status.div_busy  = div_busy;

	assign playing      = playing_q;
	assign anim_now     = anim_now_q;
	assign frame_now    = frame_now_q;
	assign finished_now = finished_now_q;
	assign queue_level  = queue_level_q;
	assign dropped      = dropped_q;

endmodule

// ===== rtl/sas_ctrl.sv =====
// Controller state machine: sequences each request through the datapath.
module sas_ctrl import sas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DECODE    = 3'd1;
	localparam logic [2:0] ST_DIV1      = 3'd2;
	localparam logic [2:0] ST_DIV1_WAIT = 3'd3;
	localparam logic [2:0] ST_BRANCH    = 3'd4;
	localparam logic [2:0] ST_DIV2_WAIT = 3'd5;
	localparam logic [2:0] ST_WB        = 3'd6;
	localparam logic [2:0] ST_OUT       = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.tick_go) begin
					cmd.prep = 1'b1;
					state_d  = ST_DIV1;
				end else begin
					cmd.simple = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				if (!status.div_busy) begin
					cmd.save_qr = 1'b1;
					state_d     = ST_BRANCH;
				end
			end
			ST_BRANCH: begin
				if (!status.slot_loop) begin
					cmd.mul = 1'b1;
					state_d = ST_WB;
				end else if (status.q_zero) begin
					cmd.wb  = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_d       = ST_DIV2_WAIT;
				end
			end
			ST_DIV2_WAIT: begin
				if (!status.div_busy) begin
					cmd.wb  = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sprite_animation_sequencer.sv =====
// Sequence: play, stop and no-op requests, and ticks with no animation playing, go from
// decode to the result register; a tick on a playing slot makes one or two passes of the
// 2-bit-per-cycle divider, plus decode, multiply and write-back steps.
// One request is in work at a time; the next is taken once the result is registered.
// Reset (arst_n low) clears playback, slot state and queue at once; queue entries
// are not cleared and configuration returns to its reset values.
module sprite_animation_sequencer import sas_pkg::*; #(
	parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [ID_W-1:0]      anim_id,
	input  logic                 restart,
	input  logic [ELAPSED_W-1:0] elapsed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 playing,
	output logic [ID_W-1:0]      anim_now,
	output logic [FRAME_W-1:0]   frame_now,
	output logic                 finished_now,
	output logic [LEVEL_W-1:0]   queue_level,
	output logic                 dropped,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	sas_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	sas_datapath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg),
		.mode         (mode),
		.anim_id      (anim_id),
		.restart      (restart),
		.elapsed      (elapsed),
		.playing      (playing),
		.anim_now     (anim_now),
		.frame_now    (frame_now),
		.finished_now (finished_now),
		.queue_level  (queue_level),
		.dropped      (dropped)
	);

	sas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

endmodule
